FILE: rtl/core/byte_crc8_crc7_engine_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte CRC engine
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef BYTE_CRC8_CRC7_ENGINE_TOP_ASSERT_SVH
`define BYTE_CRC8_CRC7_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define BCRC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bcrc assertion failed");

// Next-cycle implication, checked out of reset
`define BCRC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bcrc assertion failed");

`endif

FILE: rtl/core/bcrc_pkg.sv
// ----------------------------------------------------------------------------
// bcrc_pkg
// Types, constants and byte-update functions for the byte CRC engine.
// ----------------------------------------------------------------------------
package bcrc_pkg;

    // CRC kinds selected by the crc_kind register
    localparam logic KIND_CRC8 = 1'b0;
    localparam logic KIND_CRC7 = 1'b1;

    localparam logic [7:0]  CRC8_START     = 8'hff;
    localparam logic [7:0]  CRC7_START     = 8'h00;
    localparam logic [7:0]  CRC8_POLY_REFL = 8'h8c;
    localparam logic [14:0] CRC7_POLY      = 15'h0089;

    // Register map: byte address 4*index
    localparam int          PADDR_W      = 3;
    localparam logic [0:0]  REG_CRC_KIND = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       last;
    } bcrc_in_t;

    typedef struct packed {
        logic [7:0] crc_value;
        logic       end_of_message;
    } bcrc_out_t;

    // Everything the update unit needs for one transaction
    typedef struct packed {
        logic       kind;
        logic [7:0] running_crc;
        bcrc_in_t   item;
    } bcrc_req_t;

    // Reflected CRC-8, one byte, LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC8_POLY_REFL) : (r >> 1);
        end
        return r;
    endfunction

    // MSB-first CRC-7, one byte: remainder of ((crc<<1) ^ b) * x^7
    function automatic logic [6:0] crc7_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [14:0] r;
        r = {({crc[6:0], 1'b0} ^ b), 7'b0};
        for (int k = 14; k >= 7; k--) begin
            if (r[k]) begin
                r = r ^ (CRC7_POLY << (k - 7));
            end
        end
        return r[6:0];
    endfunction

endpackage

FILE: rtl/core/byte_crc8_crc7_engine_top.sv
// ----------------------------------------------------------------------------
// byte_crc8_crc7_engine_top
// Byte-serial CRC engine: reflected CRC-8 (1-Wire polynomial) or MSB-first CRC-7.
// ----------------------------------------------------------------------------
// The engine takes one message byte per transaction on the s_ channel and
// returns one transaction on the m_ channel carrying the running CRC after
// that byte, plus a copy of the last flag. It sustains one byte per clock
// while m_ready is held high; each byte waits in the input register, and its
// result in the result register, which drives m_data. The rate is set by
// the running-CRC feedback loop: the one-byte update is a shallow xor
// network, combinational between the input register and the result register.
// crc_kind (APB byte address 0, bit 0) selects the kind: 0 = CRC-8 with
// polynomial x^8+x^5+x^4+1, reflected, start 0xff, no final xor; 1 = CRC-7
// with x^7+x^3+1, start 0, bit 7 of the result always 0. A set first flag
// reloads the start value before its byte; without it the byte continues
// the stored CRC. Change crc_kind only while the engine is drained.
// ----------------------------------------------------------------------------
module byte_crc8_crc7_engine_top import bcrc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // byte input
    input  logic               s_valid,
    output logic               s_ready,
    input  bcrc_in_t           s_data,
    // CRC result
    output logic               m_valid,
    input  logic               m_ready,
    output bcrc_out_t          m_data,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic       in_valid_reg;
    logic       in_valid_next;
    bcrc_in_t   in_data_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    bcrc_out_t  out_data_reg;
    logic [7:0] crc_reg;
    logic       kind_reg;

    logic       advance;
    logic       s_fire;
    logic       cfg_write;
    logic       kind_sel;
    bcrc_req_t  upd_req;
    logic [7:0] upd_crc;
    bcrc_out_t  upd_result;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign kind_sel  = (paddr[PADDR_W-1:2] == REG_CRC_KIND);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = kind_sel ? {31'b0, kind_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_CRC8;
        end else if (cfg_write && kind_sel) begin
            kind_reg <= pwdata[0];
        end
    end

    // ---------------- handshake ----------------
    // Advance the input register into the result register whenever the
    // result slot is empty or is being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    // Accept a new byte while the input register is empty or moving on
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the byte in the input register until it advances
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_data;
        end
    end

    // ---------------- CRC update ----------------
    assign upd_req.kind        = kind_reg;
    assign upd_req.running_crc = crc_reg;
    assign upd_req.item        = in_data_reg;

    bcrc_update u_update (
        .req      (upd_req),
        .crc_next (upd_crc),
        .result   (upd_result)
    );

    // Commit the running CRC and the result together, once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC8_START;
        end else if (advance) begin
            crc_reg <= upd_crc;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= upd_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: rtl/core/bcrc_update.sv
// ----------------------------------------------------------------------------
// bcrc_update
// Combinational byte update of the running CRC for either kind.
// ----------------------------------------------------------------------------
module bcrc_update import bcrc_pkg::*; (
    input  bcrc_req_t  req,
    output logic [7:0] crc_next,
    output bcrc_out_t  result
);

    logic [7:0] start_crc;
    logic [7:0] crc8_val;
    logic [7:0] crc7_val;

    // Reload the start value of the selected kind on the first byte
    always_comb begin
        if (req.item.first) begin
            start_crc = (req.kind == KIND_CRC7) ? CRC7_START : CRC8_START;
        end else begin
            start_crc = req.running_crc;
        end
    end

    assign crc8_val = crc8_byte(start_crc, req.item.data_byte);
    assign crc7_val = {1'b0, crc7_byte(start_crc, req.item.data_byte)};

    assign crc_next              = (req.kind == KIND_CRC7) ? crc7_val : crc8_val;
    assign result.crc_value      = crc_next;
    assign result.end_of_message = req.item.last;

endmodule

FILE: rtl/core/bcrc_checker.sv
// ----------------------------------------------------------------------------
// bcrc_checker
// Port-level checks on the byte CRC engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_crc8_crc7_engine_top_assert.svh"

module bcrc_checker import bcrc_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input bcrc_out_t          m_data,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [31:0]        pwdata,
    input logic               pready
);

    logic kind_reg;
    logic crc7_result;

    // Track the selected kind from observed register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_CRC8;
        end else if (psel && penable && pwrite && pready
                     && (paddr[PADDR_W-1:2] == REG_CRC_KIND)) begin
            kind_reg <= pwdata[0];
        end
    end

    assign crc7_result = m_valid && (kind_reg == KIND_CRC7);

    // A drained or empty result slot never throttles the input
    `BCRC_ASSERT_NOW(a_ready_when_drained, aclk, aresetn, m_ready, s_ready)
    `BCRC_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)
    // CRC-7 results leave bit 7 clear
    `BCRC_ASSERT_NOW(a_crc7_msb_clear, aclk, aresetn, crc7_result, !m_data.crc_value[7])
    // A stalled result holds
    `BCRC_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

endmodule

bind byte_crc8_crc7_engine_top bcrc_checker u_bcrc_checker (.*);
